### rtl/tlpt_pkg.sv
// shared types and constants of the two-level page table mapper
package tlpt_pkg;

   localparam int DIR_ENTRIES = 1024;
   localparam int DIR_IDX_W   = 10;
   localparam int ADDR_W      = 32;
   localparam int FLAGS_W     = 12;
   localparam int CSR_IDX_W   = 1;

   localparam int REQ_DATA_W  = 80;
   localparam int RSP_DATA_W  = 104;

   localparam logic [ADDR_W-1:0] PAGE_MASK   = 32'hFFFF_F000;
   localparam logic [ADDR_W-1:0] PAGE_ROUND  = 32'h0000_0FFF;
   localparam logic [ADDR_W-1:0] PAGE_BYTES  = 32'h0000_1000;
   localparam logic [ADDR_W-1:0] FLAGS_RW_P  = 32'h0000_0003;
   localparam logic [ADDR_W-1:0] FLAG_PRESENT = 32'h0000_0001;

   localparam logic [ADDR_W-1:0] ALLOC_BASE_RESET = 32'h0010_0000;

   localparam logic CMD_MAP   = 1'b0;
   localparam logic CMD_FAULT = 1'b1;

   localparam logic STATUS_DONE    = 1'b0;
   localparam logic STATUS_NO_SLOT = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_ALLOC_BASE     = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_IDENTITY_TABLE = 1'b1;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP
   } state_type;

endpackage

### rtl/two_level_page_table_mapper_unit.sv
// Two-level page table mapper: a 1024-entry page directory in one RAM with a
// registered read, a page bump allocator and a slot counter. After reset the
// block sweeps the directory RAM clear, one entry per cycle, before it takes
// its first transaction; configuration writes are taken during that sweep.
// For each transaction the accept cycle issues the directory read, and the
// lookup state that follows checks the entry, updates the allocator, writes a
// new directory entry when a table is created and loads the result register.
// A new request is taken only once the previous one has left the lookup
// state, so requests do not overlap; a stalled result holds the lookup state
// until the result register frees.
module two_level_page_table_mapper_unit #(
   parameter int TABLE_SLOTS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   // configuration
   input  logic                                csr_wr_en,
   input  logic [tlpt_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tlpt_pkg::ADDR_W-1:0]         csr_wr_data,
   // requests
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [tlpt_pkg::REQ_DATA_W-1:0]     req_tdata,  // target_phys, virt_addr, flags, zero pad
   input  logic                                req_tuser,  // command
   // results
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [tlpt_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // result_addr, entry_written,
                                                            // table_created, table_addr, zero pad
   output logic                                rsp_tuser   // status
);

   import tlpt_pkg::*;

   localparam int SLOT_CNT_W = $clog2(TABLE_SLOTS + 1);

   state_type state_ff, state_in;
   logic [DIR_IDX_W-1:0]  clr_cnt_ff, clr_cnt_in;

   logic [ADDR_W-1:0]     alloc_base_ff, alloc_base_in;
   logic [ADDR_W-1:0]     identity_ff, identity_in;
   logic [ADDR_W-1:0]     next_free_ff, next_free_in;
   logic                  started_ff, started_in;
   logic [SLOT_CNT_W-1:0] next_slot_ff, next_slot_in;

   logic                  cmd_ff;
   logic [ADDR_W-1:0]     phys_ff;
   logic [ADDR_W-1:0]     virt_ff;
   logic [FLAGS_W-1:0]    flags_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0]     rsp_result_ff, rsp_result_in;
   logic [ADDR_W-1:0]     rsp_entry_ff, rsp_entry_in;
   logic                  rsp_created_ff, rsp_created_in;
   logic [ADDR_W-1:0]     rsp_table_ff, rsp_table_in;

   logic                  req_accept;
   logic                  advance;
   logic [DIR_IDX_W-1:0]  pd_idx;
   logic [ADDR_W-1:0]     dir_rd_data;
   logic                  dir_wr_en;
   logic [DIR_IDX_W-1:0]  dir_wr_addr;
   logic [ADDR_W-1:0]     dir_wr_data;

   logic [ADDR_W-1:0]     dir_val;
   logic                  present;
   logic                  fail;
   logic                  create;
   logic [ADDR_W-1:0]     base0;
   logic [ADDR_W-1:0]     page_a;
   logic [ADDR_W-1:0]     page_b;
   logic [ADDR_W-1:0]     eff_phys;
   logic [ADDR_W-1:0]     eff_flags;
   logic [ADDR_W-1:0]     table_page;
   logic [ADDR_W-1:0]     new_dir;
   logic [ADDR_W-1:0]     entry;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign advance    = (state_ff == ST_LOOKUP) && (!rsp_valid_ff || rsp_tready);
   assign pd_idx     = virt_ff[ADDR_W-1 -: DIR_IDX_W];

   tlpt_ram #(
      .WIDTH (ADDR_W),
      .DEPTH (DIR_ENTRIES)
   ) u_dir_ram (
      .clock   (clock),
      .wr_en   (dir_wr_en),
      .wr_addr (dir_wr_addr),
      .wr_data (dir_wr_data),
      .rd_en   (req_accept),
      .rd_addr (req_tdata[2*ADDR_W-1 -: DIR_IDX_W]),
      .rd_data (dir_rd_data)
   );

   // lookup and allocation
   always_comb begin
      dir_val   = (pd_idx == '0) ? (identity_ff | FLAGS_RW_P) : dir_rd_data;
      present   = dir_val[0];
      fail      = !present && (next_slot_ff >= SLOT_CNT_W'(TABLE_SLOTS));
      create    = !present && !fail;
      base0     = started_ff ? next_free_ff : alloc_base_ff;
      page_a    = (base0 + PAGE_ROUND) & PAGE_MASK;
      page_b    = page_a + PAGE_BYTES;
      if (cmd_ff == CMD_FAULT) begin
         eff_phys   = page_a;
         eff_flags  = FLAGS_RW_P;
         table_page = page_b;
      end else begin
         eff_phys   = phys_ff;
         eff_flags  = {{(ADDR_W-FLAGS_W){1'b0}}, flags_ff};
         table_page = page_a;
      end
      new_dir = table_page | eff_flags | FLAG_PRESENT;
      entry   = eff_phys | eff_flags | FLAG_PRESENT;
   end

   // directory write port: clearing sweep or new table
   always_comb begin
      dir_wr_en   = 1'b0;
      dir_wr_addr = pd_idx;
      dir_wr_data = new_dir;
      if (state_ff == ST_CLEAR) begin
         dir_wr_en   = 1'b1;
         dir_wr_addr = clr_cnt_ff;
         dir_wr_data = '0;
      end else if (advance && create) begin
         dir_wr_en = 1'b1;
      end
   end

   // control and next-state
   always_comb begin
      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      alloc_base_in = alloc_base_ff;
      identity_in   = identity_ff;
      next_free_in  = next_free_ff;
      started_in    = started_ff;
      next_slot_in  = next_slot_ff;

      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_status_in  = rsp_status_ff;
      rsp_result_in  = rsp_result_ff;
      rsp_entry_in   = rsp_entry_ff;
      rsp_created_in = rsp_created_ff;
      rsp_table_in   = rsp_table_ff;

      if (csr_wr_en) begin
         case (csr_index)
            CSR_ALLOC_BASE:     alloc_base_in = csr_wr_data;
            CSR_IDENTITY_TABLE: identity_in   = csr_wr_data;
            default: ;
         endcase
      end

      case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + DIR_IDX_W'(1);
            if (clr_cnt_ff == DIR_IDX_W'(DIR_ENTRIES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (advance) begin
               state_in       = ST_IDLE;
               rsp_valid_in   = 1'b1;
               rsp_result_in  = virt_ff & PAGE_MASK;
               if (fail) begin
                  rsp_status_in  = STATUS_NO_SLOT;
                  rsp_entry_in   = '0;
                  rsp_created_in = 1'b0;
                  rsp_table_in   = '0;
               end else begin
                  rsp_status_in  = STATUS_DONE;
                  rsp_entry_in   = entry;
                  rsp_created_in = create;
                  rsp_table_in   = (create ? new_dir : dir_val) & PAGE_MASK;
                  if (cmd_ff == CMD_FAULT || create) begin
                     started_in = 1'b1;
                  end
                  if (cmd_ff == CMD_FAULT && create) begin
                     next_free_in = page_b + PAGE_BYTES;
                  end else if (cmd_ff == CMD_FAULT || create) begin
                     next_free_in = page_b;
                  end
                  if (create) begin
                     next_slot_in = next_slot_ff + SLOT_CNT_W'(1);
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_cnt_ff    <= '0;
         alloc_base_ff <= ALLOC_BASE_RESET;
         identity_ff   <= '0;
         next_free_ff  <= '0;
         started_ff    <= 1'b0;
         next_slot_ff  <= SLOT_CNT_W'(1);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_cnt_ff    <= clr_cnt_in;
         alloc_base_ff <= alloc_base_in;
         identity_ff   <= identity_in;
         next_free_ff  <= next_free_in;
         started_ff    <= started_in;
         next_slot_ff  <= next_slot_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         cmd_ff   <= req_tuser;
         phys_ff  <= req_tdata[ADDR_W-1:0];
         virt_ff  <= req_tdata[2*ADDR_W-1:ADDR_W];
         flags_ff <= req_tdata[2*ADDR_W+FLAGS_W-1:2*ADDR_W];
      end
      rsp_status_ff  <= rsp_status_in;
      rsp_result_ff  <= rsp_result_in;
      rsp_entry_ff   <= rsp_entry_in;
      rsp_created_ff <= rsp_created_in;
      rsp_table_ff   <= rsp_table_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - 3*ADDR_W - 1){1'b0}},
                        rsp_table_ff, rsp_created_ff, rsp_entry_ff, rsp_result_ff};

`ifndef NO_ASSERTIONS
   // no transaction during the clearing sweep
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_tready)
      else $error("request taken during directory clear");

   // slot counter stays within the slot store
   a_slot_bound: assert property (@(posedge clock) disable iff (reset)
      (next_slot_ff <= SLOT_CNT_W'(TABLE_SLOTS)) && (next_slot_ff != '0))
      else $error("slot counter out of range");

   // a finished lookup always shows a result next cycle
   a_lookup_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_tvalid)
      else $error("lookup finished without result");

   // directory writes in lookup only for a real table creation
   a_dir_write: assert property (@(posedge clock) disable iff (reset)
      (dir_wr_en && state_ff == ST_LOOKUP) |-> (create && pd_idx != '0))
      else $error("unexpected directory write");

   // an error result carries no table
   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == STATUS_NO_SLOT) |-> (!rsp_created_ff && rsp_table_ff == '0))
      else $error("error result with table data");
`endif

endmodule

### rtl/tlpt_ram.sv
// generic single-port-write, registered-read synchronous ram
module tlpt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### dv/page_map_checker.sv
// scoreboard for the page table mapper: predicts each request and compares the results
module page_map_checker #(
   parameter int TABLE_SLOTS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [tlpt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tlpt_pkg::ADDR_W-1:0]     csr_wr_data,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [tlpt_pkg::REQ_DATA_W-1:0] req_tdata,   // target_phys, virt_addr, flags, zero pad
   input  logic                            req_tuser,   // command
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [tlpt_pkg::RSP_DATA_W-1:0] rsp_tdata,   // result_addr, entry_written,
                                                        // table_created, table_addr, zero pad
   input  logic                            rsp_tuser,   // status
   output int                              mismatches,
   output int                              outstanding
);

   import tlpt_pkg::*;

   typedef struct packed {
      logic              status;
      logic [ADDR_W-1:0] result_addr;
      logic [ADDR_W-1:0] entry_written;
      logic              table_created;
      logic [ADDR_W-1:0] table_addr;
   } mapping_result_type;

   logic [ADDR_W-1:0]  alloc_base_q;
   logic [ADDR_W-1:0]  identity_q;
   logic [ADDR_W-1:0]  directory_q [DIR_ENTRIES];
   int                 next_slot;
   logic [ADDR_W-1:0]  free_ptr;
   logic               alloc_live;
   mapping_result_type pending_mappings [$];
   mapping_result_type got;
   mapping_result_type want;

   // bump allocator, latches its base on first use
   function automatic logic [ADDR_W-1:0] grab_page();
      logic [ADDR_W-1:0] page;
      if (!alloc_live) begin
         free_ptr   = alloc_base_q;
         alloc_live = 1'b1;
      end
      page     = (free_ptr + PAGE_ROUND) & PAGE_MASK;
      free_ptr = page + PAGE_BYTES;
      return page;
   endfunction

   function automatic mapping_result_type predict_mapping(input logic cmd,
                                                          input logic [ADDR_W-1:0] phys,
                                                          input logic [ADDR_W-1:0] virt,
                                                          input logic [FLAGS_W-1:0] flags);
      mapping_result_type   r;
      logic [ADDR_W-1:0]    entry_flags;
      logic [ADDR_W-1:0]    page;
      logic [DIR_IDX_W-1:0] dir_idx;
      logic                 present;
      r = '0;
      dir_idx = virt[31:22];
      present = directory_q[dir_idx][0];
      r.result_addr = virt & PAGE_MASK;
      if (!present && next_slot >= TABLE_SLOTS) begin
         r.status = STATUS_NO_SLOT;
         return r;
      end
      entry_flags = {{(ADDR_W-FLAGS_W){1'b0}}, flags};
      // fault takes its data page before any table page
      if (cmd == CMD_FAULT) begin
         phys        = grab_page();
         entry_flags = FLAGS_RW_P;
      end
      if (!present) begin
         page = grab_page();
         directory_q[dir_idx] = page | entry_flags | FLAG_PRESENT;
         next_slot++;
         r.table_created = 1'b1;
      end
      r.status        = STATUS_DONE;
      r.entry_written = phys | entry_flags | FLAG_PRESENT;
      r.table_addr    = directory_q[dir_idx] & PAGE_MASK;
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         alloc_base_q = ALLOC_BASE_RESET;
         identity_q   = '0;
         foreach (directory_q[i]) directory_q[i] = '0;
         directory_q[0] = identity_q | FLAGS_RW_P;
         next_slot  = 1;
         free_ptr   = '0;
         alloc_live = 1'b0;
         pending_mappings.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_ALLOC_BASE: alloc_base_q = csr_wr_data;
               CSR_IDENTITY_TABLE: begin
                  identity_q     = csr_wr_data;
                  directory_q[0] = identity_q | FLAGS_RW_P;
               end
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tuser, rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[64],
                   rsp_tdata[96:65]};
            if (pending_mappings.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result transaction at %0t: status %0d addr %h",
                           $time, got.status, got.result_addr);
            end else begin
               want = pending_mappings.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("mismatch at %0t expected: status %0d addr %h entry %h",
                              $time, want.status, want.result_addr, want.entry_written);
                     $display("   expected: created %0d table %h",
                              want.table_created, want.table_addr);
                     $display("   got:      status %0d addr %h entry %h",
                              got.status, got.result_addr, got.entry_written);
                     $display("   got:      created %0d table %h",
                              got.table_created, got.table_addr);
                  end
               end
            end
         end
         if (req_tvalid && req_tready)
            pending_mappings.push_back(predict_mapping(req_tuser, req_tdata[31:0],
                                                       req_tdata[63:32],
                                                       req_tdata[75:64]));
      end
      outstanding = pending_mappings.size();
   end

endmodule

### dv/two_level_page_table_mapper_unit_tb.sv
// testbench top for the page table mapper: clock, reset, stimulus and verdict
module two_level_page_table_mapper_unit_tb;
   import tlpt_pkg::*;

   localparam int TABLE_SLOTS  = 16;
   localparam int TIMEOUT_TIME = 400000;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [ADDR_W-1:0]     csr_wr_data;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   int                    mismatches;
   int                    outstanding;
   bit                    req_burst;
   int unsigned           mapped_dirs [$];

   always #2 clock = ~clock;

   two_level_page_table_mapper_unit #(.TABLE_SLOTS(TABLE_SLOTS)) uut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   page_map_checker #(.TABLE_SLOTS(TABLE_SLOTS)) map_check (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   // leaves the write enable high; caller drops it after the last write
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [ADDR_W-1:0] data);
      csr_wr_en   = 1'b1;
      csr_index   = idx;
      csr_wr_data = data;
      @(negedge clock);
   endtask

   // entered and left at a falling edge; valid stays high after the transaction
   task automatic send_mapping(input logic cmd, input logic [ADDR_W-1:0] phys,
                               input logic [ADDR_W-1:0] virt,
                               input logic [FLAGS_W-1:0] flags);
      int gap;
      if ($urandom_range(0, 47) == 0) req_burst = !req_burst;
      gap = req_burst ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  = {4'b0, flags, virt, phys};
      req_tuser  = cmd;
      req_tvalid = 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid = 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   initial begin
      #(TIMEOUT_TIME);
      $display("two_level_page_table_mapper_unit verification failed");
      $finish;
   end

   // result side: random stalls, one long hold-off to back the block up
   initial begin : rsp_drain
      int gap;
      int taken;
      bit burst;
      rsp_tready = 1'b0;
      taken = 0;
      burst = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if ($urandom_range(0, 47) == 0) burst = !burst;
         gap = burst ? 0 : $urandom_range(0, 4);
         if (taken == 300) gap = 200;
         if (gap != 0) begin
            rsp_tready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready = 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         taken++;
         @(negedge clock);
      end
   end

   initial begin : stimulus
      logic              cmd;
      logic [ADDR_W-1:0] phys;
      logic [ADDR_W-1:0] virt;
      logic [FLAGS_W-1:0] flags;
      reset       = 1'b1;
      csr_wr_en   = 1'b0;
      csr_index   = CSR_ALLOC_BASE;
      csr_wr_data = '0;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = CMD_MAP;
      req_burst   = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // allocator base that wraps to page zero on the first allocation
      csr_write(CSR_ALLOC_BASE, 32'h0000_0000);
      csr_write(CSR_ALLOC_BASE, 32'hFFFF_FFFF);
      csr_write(CSR_IDENTITY_TABLE, 32'hFFFF_F000);
      csr_wr_en = 1'b0;

      send_mapping(CMD_MAP, 32'h0, 32'h0, 12'h000);
      send_mapping(CMD_MAP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF);
      send_mapping(CMD_FAULT, 32'h0, 32'h0040_0FFF, 12'h000);
      send_mapping(CMD_FAULT, 32'hFFFF_FFFF, 32'h0000_0123, 12'hFFF);
      // unaligned physical address in an existing table
      send_mapping(CMD_MAP, 32'h1234_5678, 32'h004F_F000, 12'h5A5);
      mapped_dirs = '{0, 1023, 1};
      // fill every remaining table slot
      for (int d = 2; d <= 14; d++) begin
         send_mapping((d % 2) ? CMD_FAULT : CMD_MAP, $urandom, {10'(d), 22'($urandom)},
                      12'($urandom_range(0, 4095)));
         mapped_dirs.push_back(d);
      end
      // no free slot, then the allocator must resume where it stopped
      send_mapping(CMD_MAP, 32'h0000_1000, {10'd500, 22'h0}, 12'h001);
      send_mapping(CMD_FAULT, 32'h0, {10'd501, 22'h3F_FFFF}, 12'h000);
      send_mapping(CMD_FAULT, 32'h0, {10'd7, 22'h1}, 12'h000);
      wait_drained();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               csr_write(CSR_IDENTITY_TABLE, 32'h0);
               csr_write(CSR_ALLOC_BASE, 32'h0);
            end
            1: begin
               csr_write(CSR_IDENTITY_TABLE, $urandom_range(0, 32'hFFFF_F000));
               csr_write(CSR_ALLOC_BASE, $urandom);
            end
            2: begin
               csr_write(CSR_IDENTITY_TABLE, 32'h0000_0FFF);
               csr_write(CSR_ALLOC_BASE, 32'hFFFF_FFFF);
            end
            default: begin
               csr_write(CSR_ALLOC_BASE, ALLOC_BASE_RESET);
               csr_write(CSR_IDENTITY_TABLE, $urandom & PAGE_MASK);
            end
         endcase
         csr_wr_en = 1'b0;
         for (int n = 0; n < 195; n++) begin
            if (phase == 2 && n == 100) wait_drained();
            cmd   = 1'($urandom_range(0, 1));
            phys  = $urandom;
            if ($urandom_range(0, 3) == 0) phys[11:0] = '0;
            flags = 12'($urandom_range(0, 4095));
            virt  = $urandom;
            // mostly directories that already own a table
            if ($urandom_range(0, 99) < 85)
               virt[31:22] = 10'(mapped_dirs[$urandom_range(0, mapped_dirs.size() - 1)]);
            send_mapping(cmd, phys, virt, flags);
         end
         wait_drained();
      end

      repeat (8) @(negedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("two_level_page_table_mapper_unit verification clean");
      else
         $display("two_level_page_table_mapper_unit verification failed");
      $finish;
   end

endmodule

### sim.f
rtl/tlpt_pkg.sv
rtl/tlpt_ram.sv
rtl/two_level_page_table_mapper_unit.sv
dv/page_map_checker.sv
dv/two_level_page_table_mapper_unit_tb.sv
